FILE: rtl/core/jlvp_pkg.sv
`timescale 1ns / 1ps
package jlvp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int DIV_STEPS      = 64;

  localparam logic [31:0] US_PER_S    = 32'd1000000;
  localparam logic [30:0] DECEL_RESET = 31'd65536;
  localparam logic [30:0] JERK_RESET  = 31'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // configuration register indexes
  localparam logic CFG_DECEL = 1'b0;
  localparam logic CFG_JERK  = 1'b1;

  localparam logic [1:0] STATUS_UNCHANGED  = 2'd0;
  localparam logic [1:0] STATUS_MODIFIED   = 2'd1;
  localparam logic [1:0] STATUS_TIME_ERROR = 2'd2;

  typedef enum logic [1:0] {
    MODE_ERROR,
    MODE_KEEP,
    MODE_PASS,
    MODE_SMOOTH
  } mode_e;

  typedef struct packed {
    logic               store;
    logic               last;
    mode_e              mode;
    logic [31:0]        ptime;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic signed [31:0] ego_v;
    logic signed [31:0] ego_a;
  } jlvp_rec_t;

  // request to the shared multiply-divide unit: sat32(a * b / c), toward zero
  typedef struct packed {
    logic               start;
    logic signed [32:0] a;
    logic [31:0]        b;
    logic [31:0]        c;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
  } md_rsp_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? S32_MIN : S32_MAX;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // crossed bounds give lo for x below lo and hi otherwise
  function automatic logic signed [31:0] clamp(input logic signed [31:0] x,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/jlvp_fifo.sv
`timescale 1ns / 1ps
module jlvp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == NW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/jlvp_front.sv
`timescale 1ns / 1ps
module jlvp_front import jlvp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        point_time_i,
  input  logic signed [31:0] point_speed_i,
  input  logic signed [31:0] point_accel_i,
  input  logic               limit_valid_i,
  input  logic [30:0]        speed_limit_i,
  input  logic               ego_speed_valid_i,
  input  logic [30:0]        ego_speed_i,
  input  logic               ego_accel_valid_i,
  input  logic signed [31:0] ego_accel_i,
  input  logic               in_last_i,
  input  logic               full_i,
  output logic               push_o,
  output jlvp_rec_t          rec_o
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]      count_q;
  logic               capped_q, err_q, egosv_q, egoav_q;
  logic [31:0]        prev_time_q;
  logic [30:0]        fcap_q, egos_q;
  logic signed [31:0] egoa_q, fspeed_q, faccel_q;

  logic               acc, store, first, terr, over;
  logic               err_n, cap_n, skip, egosv, egoav;
  logic [30:0]        fcap_n, egos;
  logic signed [31:0] lim_s, speed_c, accel_c, egoa, fspeed, faccel, ego_v, ego_a;
  logic [35:0]        cap_x20, ego_x17;

  assign in_ready_o = ~full_i;
  assign acc        = in_valid_i & ~full_i;
  assign push_o     = acc;

  always_comb begin
    store   = (count_q < CW'(MAX_POINTS));
    first   = (count_q == '0);
    terr    = store && !first && (point_time_i <= prev_time_q);
    lim_s   = $signed({1'b0, speed_limit_i});
    over    = limit_valid_i && (point_speed_i > lim_s);
    speed_c = over ? lim_s : point_speed_i;
    accel_c = (over && point_accel_i > 32'sd0) ? 32'sd0 : point_accel_i;
    err_n   = err_q | terr;
    cap_n   = capped_q | (store & over);
    fcap_n  = capped_q ? fcap_q : speed_limit_i;
    // ego state is taken from the first point of the trajectory
    egosv   = (store && first) ? ego_speed_valid_i : egosv_q;
    egos    = (store && first) ? ego_speed_i : egos_q;
    egoav   = (store && first) ? ego_accel_valid_i : egoav_q;
    egoa    = (store && first) ? ego_accel_i : egoa_q;
    fspeed  = (store && first) ? point_speed_i : fspeed_q;
    faccel  = (store && first) ? point_accel_i : faccel_q;
    ego_v   = egosv ? $signed({1'b0, egos}) : fspeed;
    ego_a   = egoav ? egoa : faccel;
    // deadband: first capped speed above 85% of ego speed
    cap_x20 = {5'b0, fcap_n} * 36'd20;
    ego_x17 = {5'b0, egos} * 36'd17;
    skip    = egosv && (cap_x20 > ego_x17);

    rec_o.store = store;
    rec_o.last  = in_last_i;
    rec_o.ptime = point_time_i;
    rec_o.speed = speed_c;
    rec_o.accel = accel_c;
    rec_o.ego_v = ego_v;
    rec_o.ego_a = ego_a;
    priority if (err_n) begin
      rec_o.mode = MODE_ERROR;
    end else if (!cap_n) begin
      rec_o.mode = MODE_KEEP;
    end else if (skip) begin
      rec_o.mode = MODE_PASS;
    end else begin
      rec_o.mode = MODE_SMOOTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      capped_q <= 1'b0;
      err_q    <= 1'b0;
      egosv_q  <= 1'b0;
      egoav_q  <= 1'b0;
    end else if (acc) begin
      if (store && first) begin
        egosv_q <= ego_speed_valid_i;
        egoav_q <= ego_accel_valid_i;
      end
      if (in_last_i) begin
        count_q  <= '0;
        capped_q <= 1'b0;
        err_q    <= 1'b0;
      end else if (store) begin
        count_q  <= count_q + 1'b1;
        capped_q <= cap_n;
        err_q    <= err_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && store) begin
      prev_time_q <= point_time_i;
      fcap_q      <= fcap_n;
      if (first) begin
        egos_q   <= ego_speed_i;
        egoa_q   <= ego_accel_i;
        fspeed_q <= point_speed_i;
        faccel_q <= point_accel_i;
      end
    end
  end

endmodule

FILE: rtl/core/jlvp_muldiv.sv
`timescale 1ns / 1ps
module jlvp_muldiv import jlvp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam int SW        = $clog2(DIV_STEPS);
  localparam int RCP_STEPS = 4;
  // floor(n / 15625) equals (n * {RCP_HI, RCP_LO}) >> 59 for n below 2^45
  localparam logic [13:0] RCP_HI    = 14'h218d;
  localparam logic [31:0] RCP_LO    = 32'hef41_6bdc;
  // a product at or above this scales to 2^31 or more and saturates
  localparam logic [63:0] RCP_LIMIT = 64'h0007_a120_0000_0000;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_DIV,
    M_RCP,
    M_FIN
  } md_state_e;

  md_state_e          state_q;
  logic               neg_q, done_q, recip_q;
  logic [31:0]        amag_q, b_q, c_q, rem_q;
  logic [63:0]        quo_q;
  logic [95:0]        acc_q;
  logic [SW-1:0]      step_q;
  logic signed [31:0] res_q;

  logic [32:0] a_neg, shifted, diff;
  logic        ge, ovf;
  logic [44:0] nrm;
  logic [31:0] px, py;
  logic [63:0] pp;
  logic [95:0] addend, acc_nx;

  assign a_neg   = -req_i.a;
  assign shifted = {rem_q, quo_q[63]};
  assign diff    = shifted - {1'b0, c_q};
  assign ge      = ~diff[32];

  // division by one second in microseconds: 2^6 * 15625, by reciprocal
  assign ovf = (quo_q >= RCP_LIMIT);
  assign nrm = quo_q[50:6];
  assign pp  = {32'b0, px} * {32'b0, py};
  assign acc_nx = acc_q + addend;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin
        px     = nrm[31:0];
        py     = RCP_LO;
        addend = {32'b0, pp};
      end
      2'd1: begin
        px     = nrm[31:0];
        py     = {18'b0, RCP_HI};
        addend = {pp, 32'b0};
      end
      2'd2: begin
        px     = {19'b0, nrm[44:32]};
        py     = RCP_LO;
        addend = {pp, 32'b0};
      end
      default: begin
        px     = {19'b0, nrm[44:32]};
        py     = {18'b0, RCP_HI};
        addend = {pp[31:0], 64'b0};
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          state_q <= recip_q ? M_RCP : M_DIV;
        end
        M_DIV: begin
          if (step_q == SW'(DIV_STEPS - 1)) begin
            state_q <= M_FIN;
          end
        end
        M_RCP: begin
          if (step_q == SW'(RCP_STEPS - 1)) begin
            state_q <= M_FIN;
          end
        end
        M_FIN: begin
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          neg_q   <= req_i.a[32];
          amag_q  <= req_i.a[32] ? a_neg[31:0] : req_i.a[31:0];
          b_q     <= req_i.b;
          c_q     <= req_i.c;
          recip_q <= (req_i.c == US_PER_S);
        end
      end
      M_MUL: begin
        quo_q  <= {32'b0, amag_q} * {32'b0, b_q};
        rem_q  <= '0;
        acc_q  <= '0;
        step_q <= '0;
      end
      M_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_q  <= ge ? diff[31:0] : shifted[31:0];
        quo_q  <= {quo_q[62:0], ge};
        step_q <= step_q + 1'b1;
      end
      M_RCP: begin
        // one 32x32 partial product of the reciprocal multiply per cycle
        acc_q  <= acc_nx;
        step_q <= step_q + 1'b1;
        if (step_q == SW'(RCP_STEPS - 1)) begin
          quo_q <= ovf ? 64'h8000_0000 : {33'b0, acc_nx[89:59]};
        end
      end
      M_FIN: begin
        if (neg_q) begin
          res_q <= (quo_q > 64'h8000_0000) ? S32_MIN : $signed(-quo_q[31:0]);
        end else begin
          res_q <= (quo_q > 64'h7fff_ffff) ? S32_MAX : $signed(quo_q[31:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/jlvp_back.sv
`timescale 1ns / 1ps
module jlvp_back import jlvp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [30:0]        decel_i,
  input  logic [30:0]        jerk_i,
  input  logic               empty_i,
  input  jlvp_rec_t          rec_i,
  output logic               pop_o,
  output md_req_t            md_req_o,
  input  md_rsp_t            md_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_speed_o,
  output logic signed [31:0] out_accel_o,
  output logic [1:0]         status_o,
  output logic               out_last_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_POP,
    S_F_RD, S_F_CHK, S_F_M1, S_F_M2, S_F_M3, S_F_CL, S_F_M4, S_F_NEXT,
    S_B_INIT, S_B_LRD, S_B_LD, S_B_RD, S_B_CHK, S_B_M1, S_B_M2, S_B_M3, S_B_NEXT,
    S_T_INIT, S_T_RD, S_T_CHK, S_T_M1, S_T_M2, S_T_M3, S_T_NEXT, S_T_END,
    S_E_RD, S_E_LD
  } back_state_e;

  back_state_e        state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d, n_q, n_d;
  logic [AW-1:0]      idx_q, idx_d;
  mode_e              mode_q, mode_d;
  logic signed [31:0] egov_q, egov_d, egoa_q, egoa_d;
  logic signed [31:0] accv_q, accv_d, acca_q, acca_d;
  logic [31:0]        lt_q, lt_d, dt_q, dt_d, t_q, t_d;
  logic signed [31:0] v_q, v_d, lo_q, lo_d, hi_q, hi_d, r0_q, r0_d, tmp_q, tmp_d;
  logic               ovalid_q, ovalid_d, olast_q, olast_d;
  logic signed [31:0] ospeed_q, ospeed_d, oaccel_q, oaccel_d;
  logic [1:0]         ostatus_q, ostatus_d;

  // trajectory stores
  logic [31:0]        time_mem [MAX_POINTS];
  logic signed [31:0] spd_mem  [MAX_POINTS];
  logic signed [31:0] acc_mem  [MAX_POINTS];
  logic [31:0]        t_rd_q;
  logic signed [31:0] s_rd_q, a_rd_q;
  logic               rd_en, t_we, s_we, a_we;
  logic [AW-1:0]      t_wa, s_wa, a_wa;
  logic [31:0]        t_wd;
  logic signed [31:0] s_wd, a_wd;

  logic signed [31:0] negd, jerk_s, res, safe, vn, cc, cvn;
  logic signed [32:0] dtf, dtb;
  logic [31:0]        dtv;
  logic               at_last, done;

  assign negd   = 32'sd0 - $signed({1'b0, decel_i});
  assign jerk_s = $signed({1'b0, jerk_i});
  assign res    = md_rsp_i.res;
  assign done   = md_rsp_i.done;

  assign out_valid_o = ovalid_q;
  assign out_speed_o = ospeed_q;
  assign out_accel_o = oaccel_q;
  assign status_o    = ostatus_q;
  assign out_last_o  = olast_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    idx_d     = idx_q;
    mode_d    = mode_q;
    egov_d    = egov_q;
    egoa_d    = egoa_q;
    accv_d    = accv_q;
    acca_d    = acca_q;
    lt_d      = lt_q;
    dt_d      = dt_q;
    t_d       = t_q;
    v_d       = v_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    r0_d      = r0_q;
    tmp_d     = tmp_q;
    ovalid_d  = ovalid_q & ~out_ready_i;
    olast_d   = olast_q;
    ospeed_d  = ospeed_q;
    oaccel_d  = oaccel_q;
    ostatus_d = ostatus_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    t_we      = 1'b0;
    s_we      = 1'b0;
    a_we      = 1'b0;
    t_wa      = cnt_q[AW-1:0];
    s_wa      = idx_q;
    a_wa      = idx_q;
    t_wd      = rec_i.ptime;
    s_wd      = rec_i.speed;
    a_wd      = rec_i.accel;
    md_req_o  = '0;
    safe      = sat_sub(accv_q, res);
    vn        = clamp(v_q, smin(r0_q, tmp_q), smax(r0_q, tmp_q));
    cc        = smax(negd, clamp(res, lo_q, hi_q));
    cvn       = sat_add(accv_q, res);
    dtf       = $signed({1'b0, t_rd_q}) - $signed({1'b0, lt_q});
    dtb       = $signed({1'b0, lt_q}) - $signed({1'b0, t_rd_q});
    dtv       = (dtb <= 33'sd0) ? 32'd1 : dtb[31:0];
    at_last   = (CW'(idx_q) == n_q - CW'(1));

    unique case (state_q)
      S_POP: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (rec_i.store) begin
            t_we  = 1'b1;
            s_we  = 1'b1;
            a_we  = 1'b1;
            s_wa  = cnt_q[AW-1:0];
            a_wa  = cnt_q[AW-1:0];
            cnt_d = cnt_q + 1'b1;
          end
          if (rec_i.last) begin
            n_d     = cnt_q + CW'(rec_i.store);
            mode_d  = rec_i.mode;
            egov_d  = rec_i.ego_v;
            egoa_d  = rec_i.ego_a;
            accv_d  = rec_i.ego_v;
            acca_d  = rec_i.ego_a;
            lt_d    = '0;
            idx_d   = '0;
            state_d = (rec_i.mode == MODE_SMOOTH) ? S_F_RD : S_E_RD;
          end
        end
      end

      // forward reachability
      S_F_RD: begin
        rd_en   = 1'b1;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        t_d  = t_rd_q;
        v_d  = s_rd_q;
        dt_d = dtf[31:0];
        if (dtf <= 33'sd0) begin
          s_we    = 1'b1;
          s_wd    = clamp(s_rd_q, 32'sd0, smax(32'sd0, accv_q));
          state_d = S_F_NEXT;
        end else begin
          md_req_o = '{start: 1'b1, a: {jerk_s[31], jerk_s}, b: dtf[31:0], c: US_PER_S};
          state_d  = S_F_M1;
        end
      end
      S_F_M1: begin
        if (done) begin
          lo_d     = smax(negd, sat_sub(acca_q, res));
          hi_d     = sat_add(acca_q, res);
          md_req_o = '{start: 1'b1, a: {lo_d[31], lo_d}, b: dt_q, c: US_PER_S};
          state_d  = S_F_M2;
        end
      end
      S_F_M2: begin
        if (done) begin
          r0_d     = smax(32'sd0, cvn);
          md_req_o = '{start: 1'b1, a: {hi_q[31], hi_q}, b: dt_q, c: US_PER_S};
          state_d  = S_F_M3;
        end
      end
      S_F_M3: begin
        if (done) begin
          tmp_d   = smax(32'sd0, cvn);
          state_d = S_F_CL;
        end
      end
      S_F_CL: begin
        s_we     = 1'b1;
        s_wd     = vn;
        tmp_d    = vn;
        md_req_o = '{start: 1'b1, a: {vn[31], vn} - {accv_q[31], accv_q},
                     b: US_PER_S, c: dt_q};
        state_d  = S_F_M4;
      end
      S_F_M4: begin
        if (done) begin
          acca_d  = clamp(res, lo_q, hi_q);
          accv_d  = tmp_q;
          lt_d    = t_q;
          state_d = S_F_NEXT;
        end
      end
      S_F_NEXT: begin
        if (at_last) begin
          state_d = S_B_INIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_F_RD;
        end
      end

      // backward deceleration limiting, k+1 values carried in accv/acca/lt
      S_B_INIT: begin
        if (n_q == CW'(1)) begin
          state_d = S_T_INIT;
        end else begin
          idx_d   = AW'(n_q - CW'(1));
          state_d = S_B_LRD;
        end
      end
      S_B_LRD: begin
        rd_en   = 1'b1;
        state_d = S_B_LD;
      end
      S_B_LD: begin
        accv_d  = s_rd_q;
        acca_d  = a_rd_q;
        lt_d    = t_rd_q;
        idx_d   = idx_q - 1'b1;
        state_d = S_B_RD;
      end
      S_B_RD: begin
        rd_en   = 1'b1;
        state_d = S_B_CHK;
      end
      S_B_CHK: begin
        dt_d     = dtv;
        v_d      = s_rd_q;
        t_d      = t_rd_q;
        md_req_o = '{start: 1'b1, a: {jerk_s[31], jerk_s}, b: dtv, c: US_PER_S};
        state_d  = S_B_M1;
      end
      S_B_M1: begin
        if (done) begin
          lo_d     = smax(negd, sat_sub(acca_q, res));
          md_req_o = '{start: 1'b1, a: {lo_d[31], lo_d}, b: dt_q, c: US_PER_S};
          state_d  = S_B_M2;
        end
      end
      S_B_M2: begin
        if (done) begin
          if (v_q > safe) begin
            s_we    = 1'b1;
            s_wd    = safe;
            a_we    = 1'b1;
            a_wd    = lo_q;
            accv_d  = safe;
            acca_d  = lo_q;
            lt_d    = t_q;
            state_d = S_B_NEXT;
          end else begin
            md_req_o = '{start: 1'b1, a: {accv_q[31], accv_q} - {v_q[31], v_q},
                         b: US_PER_S, c: dt_q};
            state_d  = S_B_M3;
          end
        end
      end
      S_B_M3: begin
        if (done) begin
          a_we    = 1'b1;
          a_wd    = res;
          acca_d  = res;
          accv_d  = v_q;
          lt_d    = t_q;
          state_d = S_B_NEXT;
        end
      end
      S_B_NEXT: begin
        if (idx_q == '0) begin
          state_d = S_T_INIT;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_B_RD;
        end
      end

      // jerk-limited tracking
      S_T_INIT: begin
        accv_d  = egov_q;
        acca_d  = egoa_q;
        lt_d    = '0;
        idx_d   = '0;
        state_d = S_T_RD;
      end
      S_T_RD: begin
        rd_en   = 1'b1;
        state_d = S_T_CHK;
      end
      S_T_CHK: begin
        t_d  = t_rd_q;
        v_d  = s_rd_q;
        dt_d = dtf[31:0];
        if (dtf <= 33'sd0) begin
          s_we    = 1'b1;
          s_wd    = accv_q;
          a_we    = (idx_q != '0);
          a_wa    = idx_q - 1'b1;
          a_wd    = acca_q;
          state_d = S_T_NEXT;
        end else begin
          md_req_o = '{start: 1'b1, a: {jerk_s[31], jerk_s}, b: dtf[31:0], c: US_PER_S};
          state_d  = S_T_M1;
        end
      end
      S_T_M1: begin
        if (done) begin
          lo_d     = sat_sub(acca_q, res);
          hi_d     = sat_add(acca_q, res);
          md_req_o = '{start: 1'b1, a: {v_q[31], v_q} - {accv_q[31], accv_q},
                       b: US_PER_S, c: dt_q};
          state_d  = S_T_M2;
        end
      end
      S_T_M2: begin
        if (done) begin
          tmp_d    = cc;
          md_req_o = '{start: 1'b1, a: {cc[31], cc}, b: dt_q, c: US_PER_S};
          state_d  = S_T_M3;
        end
      end
      S_T_M3: begin
        if (done) begin
          s_we    = 1'b1;
          s_wd    = smax(32'sd0, cvn);
          a_we    = (idx_q != '0);
          a_wa    = idx_q - 1'b1;
          a_wd    = tmp_q;
          accv_d  = cvn;
          acca_d  = tmp_q;
          lt_d    = t_q;
          state_d = S_T_NEXT;
        end
      end
      S_T_NEXT: begin
        if (at_last) begin
          state_d = S_T_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_T_RD;
        end
      end
      S_T_END: begin
        a_we    = 1'b1;
        a_wd    = 32'sd0;
        idx_d   = '0;
        state_d = S_E_RD;
      end

      // emission through the output register
      S_E_RD: begin
        rd_en   = 1'b1;
        state_d = S_E_LD;
      end
      S_E_LD: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          olast_d  = at_last;
          unique case (mode_q)
            MODE_ERROR: begin
              ospeed_d  = 32'sd0;
              oaccel_d  = 32'sd0;
              ostatus_d = STATUS_TIME_ERROR;
            end
            MODE_KEEP: begin
              ospeed_d  = s_rd_q;
              oaccel_d  = a_rd_q;
              ostatus_d = STATUS_UNCHANGED;
            end
            default: begin
              ospeed_d  = s_rd_q;
              oaccel_d  = a_rd_q;
              ostatus_d = STATUS_MODIFIED;
            end
          endcase
          if (at_last) begin
            cnt_d   = '0;
            state_d = S_POP;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_E_RD;
          end
        end
      end
      default: state_d = S_POP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_POP;
      cnt_q    <= '0;
      n_q      <= '0;
      idx_q    <= '0;
      mode_q   <= MODE_KEEP;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      idx_q    <= idx_d;
      mode_q   <= mode_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    egov_q    <= egov_d;
    egoa_q    <= egoa_d;
    accv_q    <= accv_d;
    acca_q    <= acca_d;
    lt_q      <= lt_d;
    dt_q      <= dt_d;
    t_q       <= t_d;
    v_q       <= v_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    r0_q      <= r0_d;
    tmp_q     <= tmp_d;
    ospeed_q  <= ospeed_d;
    oaccel_q  <= oaccel_d;
    ostatus_q <= ostatus_d;
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      time_mem[t_wa] <= t_wd;
    end
    if (s_we) begin
      spd_mem[s_wa] <= s_wd;
    end
    if (a_we) begin
      acc_mem[a_wa] <= a_wd;
    end
    if (rd_en) begin
      t_rd_q <= time_mem[idx_q];
      s_rd_q <= spd_mem[idx_q];
      a_rd_q <= acc_mem[idx_q];
    end
  end

endmodule

FILE: rtl/core/jerk_limited_velocity_profile_unit.sv
`timescale 1ns / 1ps
// Jerk-limited velocity profile over a buffered trajectory of up to MAX_POINTS points.
// Input channel (in_valid_i/in_ready_o): one trajectory point per request; the ego
// fields are read on the first point, in_last_i closes the trajectory.
// Output channel (out_valid_o/out_ready_i): one result per stored point, in order,
// out_last_o on the final one. A full output register waits for out_ready_i while
// the front keeps taking points into a FIFO_DEPTH-entry queue.
// Throughput: points are stored at one per cycle until the queue fills behind a
// trajectory that is being processed. After the last point the back end runs three
// passes: forward reachability (3 dt-products and 1 quotient per point), backward
// limiting (2 dt-products and at most 1 quotient) and tracking (2 and 1). One shared
// unit does them all: a dt-product scales by dt and divides by 1e6 through a
// reciprocal multiply, a quotient by dt takes 64 restoring divide steps. Emission
// reads each point, then loads it into the output register once that is free.
// Trajectories that need no smoothing go straight to emission.
// Configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i) is for the user to write only while
// no trajectory is in flight; the block itself does not enforce this. Reset clears
// all control state and loads both limits with 1.0; the point stores need no clearing.
module jerk_limited_velocity_profile_unit import jlvp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        point_time_i,
  input  logic signed [31:0] point_speed_i,
  input  logic signed [31:0] point_accel_i,
  input  logic               limit_valid_i,
  input  logic [30:0]        speed_limit_i,
  input  logic               ego_speed_valid_i,
  input  logic [30:0]        ego_speed_i,
  input  logic               ego_accel_valid_i,
  input  logic signed [31:0] ego_accel_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_speed_o,
  output logic signed [31:0] out_accel_o,
  output logic [1:0]         status_o,
  output logic               out_last_o
);

  localparam int REC_W = $bits(jlvp_rec_t);

  logic [30:0] decel_q, jerk_q;
  jlvp_rec_t   push_rec, head_rec;
  logic        push, full, pop, empty;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decel_q <= DECEL_RESET;
      jerk_q  <= JERK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DECEL: decel_q <= cfg_wdata_i;
        CFG_JERK:  jerk_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  jlvp_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .point_time_i,
    .point_speed_i,
    .point_accel_i,
    .limit_valid_i,
    .speed_limit_i,
    .ego_speed_valid_i,
    .ego_speed_i,
    .ego_accel_valid_i,
    .ego_accel_i,
    .in_last_i,
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  jlvp_fifo #(
    .W    (REC_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .wdata_i(push_rec),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(head_rec),
    .empty_o(empty)
  );

  jlvp_muldiv u_muldiv (
    .clk_i,
    .rst_ni,
    .req_i(md_req),
    .rsp_o(md_rsp)
  );

  jlvp_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .decel_i (decel_q),
    .jerk_i  (jerk_q),
    .empty_i (empty),
    .rec_i   (head_rec),
    .pop_o   (pop),
    .md_req_o(md_req),
    .md_rsp_i(md_rsp),
    .out_valid_o,
    .out_ready_i,
    .out_speed_o,
    .out_accel_o,
    .status_o,
    .out_last_o
  );

`ifndef NO_ASSERTIONS
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_TIME_ERROR |-> out_speed_o == '0 && out_accel_o == '0)
    else $error("time error result carries nonzero speed or acceleration");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STATUS_UNCHANGED || status_o == STATUS_MODIFIED ||
                    status_o == STATUS_TIME_ERROR)
    else $error("undefined status code on output");
`endif

endmodule

FILE: sim/tb_jerk_limited_velocity_profile_unit.sv
`timescale 1ns / 1ps
module tb_jerk_limited_velocity_profile_unit;
  import jlvp_pkg::*;

  localparam int NPTS       = 64;
  localparam int STALL_MAX  = 200000;
  localparam int SETTLE     = 40;
  localparam int ITEMS_GOAL = 360;

  typedef enum int {
    TRAJ_CLEAN,
    TRAJ_BAD_TIME,
    TRAJ_ZERO_START,
    TRAJ_WILD
  } traj_kind_e;

  typedef struct {
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic [1:0]         status;
    logic               last;
  } point_result_t;

  class velocity_profile_board;
    bit [30:0] decel;
    bit [30:0] jerk;
    bit [31:0] t_mem[NPTS];
    int        v_mem[NPTS];
    int        a_mem[NPTS];
    longint    first_v, first_a, ego_v, ego_a;
    bit        ego_v_ok, ego_a_ok, capped, t_bad;
    int        count, cap_idx;
    point_result_t result_q[$];
    int        errors, checked, trajs, smoothed;

    function new();
      decel = DECEL_RESET;
      jerk = JERK_RESET;
      count = 0;
      cap_idx = 0;
      capped = 0;
      t_bad = 0;
      ego_v_ok = 0;
      ego_a_ok = 0;
      ego_v = 0;
      ego_a = 0;
      first_v = 0;
      first_a = 0;
      errors = 0;
      checked = 0;
      trajs = 0;
      smoothed = 0;
    endfunction

    function void report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint lmax(longint a, longint b);
      return (a > b) ? a : b;
    endfunction

    function longint lmin(longint a, longint b);
      return (a < b) ? a : b;
    endfunction

    function longint lclamp(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint times_dt(longint x, longint dt);
      return sat32((sat32(x) * dt) / 1000000);
    endfunction

    function longint over_dt(longint x, longint dt);
      return sat32((x * 1000000) / dt);
    endfunction

    function void smooth_profile(int n);
      longint d, j, v0, a0, rv, ra, lt, cv, ca, dt, v, mina, maxa, r0, r1;
      longint ta, safe, lo, hi, c;
      d = decel;
      j = jerk;
      v0 = ego_v_ok ? ego_v : first_v;
      a0 = ego_a_ok ? ego_a : first_a;
      // reachable band from the ego state
      rv = v0;
      ra = a0;
      lt = 0;
      for (int i = 0; i < n; i++) begin
        dt = longint'(t_mem[i]) - lt;
        v = v_mem[i];
        if (dt <= 0) begin
          v_mem[i] = int'(lclamp(v, 0, lmax(0, rv)));
          continue;
        end
        mina = lmax(-d, sat32(ra - times_dt(j, dt)));
        maxa = sat32(ra + times_dt(j, dt));
        r0 = lmax(0, sat32(rv + times_dt(mina, dt)));
        r1 = lmax(0, sat32(rv + times_dt(maxa, dt)));
        v = lclamp(v, lmin(r0, r1), lmax(r0, r1));
        v_mem[i] = int'(v);
        ra = lclamp(over_dt(v - rv, dt), mina, maxa);
        rv = v;
        lt = t_mem[i];
      end
      // backward braking limit
      for (int k = n - 2; k >= 0; k--) begin
        dt = longint'(t_mem[k + 1]) - longint'(t_mem[k]);
        if (dt <= 0) dt = 1;
        ta = lmax(-d, sat32(longint'(a_mem[k + 1]) - times_dt(j, dt)));
        safe = sat32(longint'(v_mem[k + 1]) - times_dt(ta, dt));
        if (v_mem[k] > safe) begin
          v_mem[k] = int'(safe);
          a_mem[k] = int'(ta);
        end else begin
          a_mem[k] = int'(over_dt(longint'(v_mem[k + 1]) - v_mem[k], dt));
        end
      end
      // jerk-limited tracking
      cv = v0;
      ca = a0;
      lt = 0;
      for (int i = 0; i < n; i++) begin
        dt = longint'(t_mem[i]) - lt;
        if (dt <= 0) begin
          v_mem[i] = int'(cv);
          if (i > 0) a_mem[i - 1] = int'(ca);
          continue;
        end
        lo = sat32(ca - times_dt(j, dt));
        hi = sat32(ca + times_dt(j, dt));
        c = lclamp(over_dt(longint'(v_mem[i]) - cv, dt), lo, hi);
        c = lmax(-d, c);
        cv = sat32(cv + times_dt(c, dt));
        v_mem[i] = int'(lmax(0, cv));
        if (i > 0) a_mem[i - 1] = int'(c);
        ca = c;
        lt = t_mem[i];
      end
      a_mem[n - 1] = 0;
    endfunction

    function void note_point(bit [31:0] t, logic signed [31:0] spd, logic signed [31:0] acc,
                             bit lv, bit [30:0] lim, bit evv, bit [30:0] ev, bit eav,
                             logic signed [31:0] ea, bit last);
      int idx, n;
      longint v, a;
      bit [1:0] st;
      bit blank;
      point_result_t r;
      if (count < NPTS) begin
        idx = count;
        v = spd;
        a = acc;
        if (idx == 0) begin
          ego_v_ok = evv;
          ego_v = ev;
          ego_a_ok = eav;
          ego_a = ea;
          first_v = v;
          first_a = a;
        end else if (t <= t_mem[idx - 1]) begin
          t_bad = 1;
        end
        t_mem[idx] = t;
        if (lv && v > longint'(lim)) begin
          v = lim;
          a = lmin(a, 0);
          if (!capped) begin
            capped = 1;
            cap_idx = idx;
          end
        end
        v_mem[idx] = int'(v);
        a_mem[idx] = int'(a);
        count = idx + 1;
      end
      if (!last) return;
      n = count;
      blank = 0;
      if (t_bad) begin
        st = STATUS_TIME_ERROR;
        blank = 1;
      end else if (!capped) begin
        st = STATUS_UNCHANGED;
      end else if (ego_v_ok && longint'(v_mem[cap_idx]) * 20 > ego_v * 17) begin
        st = STATUS_MODIFIED;
      end else begin
        smooth_profile(n);
        smoothed++;
        st = STATUS_MODIFIED;
      end
      for (int i = 0; i < n; i++) begin
        r.speed = blank ? 32'sd0 : v_mem[i];
        r.accel = blank ? 32'sd0 : a_mem[i];
        r.status = st;
        r.last = (i == n - 1);
        result_q.push_back(r);
      end
      trajs++;
      count = 0;
      cap_idx = 0;
      capped = 0;
      t_bad = 0;
    endfunction

    function void check_result(logic signed [31:0] spd, logic signed [31:0] acc,
                               logic [1:0] st, logic last);
      point_result_t e;
      checked++;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected result speed=%0d accel=%0d status=%0d", spd, acc, st));
        return;
      end
      e = result_q.pop_front();
      if (spd !== e.speed || acc !== e.accel || st !== e.status || last !== e.last)
        report($sformatf({"result %0d: got v=%0d a=%0d st=%0d last=%0d, ",
                          "want v=%0d a=%0d st=%0d last=%0d"},
                         checked, spd, acc, st, last, e.speed, e.accel, e.status, e.last));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [30:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [31:0]        point_time_i;
  logic signed [31:0] point_speed_i;
  logic signed [31:0] point_accel_i;
  logic               limit_valid_i;
  logic [30:0]        speed_limit_i;
  logic               ego_speed_valid_i;
  logic [30:0]        ego_speed_i;
  logic               ego_accel_valid_i;
  logic signed [31:0] ego_accel_i;
  logic               in_last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_speed_o;
  logic signed [31:0] out_accel_o;
  logic [1:0]         status_o;
  logic               out_last_o;

  velocity_profile_board board = new();
  bit no_idle = 0;
  bit held = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  jerk_limited_velocity_profile_unit u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // request and result monitor, plus the stall watchdog
  always @(posedge clk_i) begin
    quiet_cycles <= quiet_cycles + 1;
    if (out_valid_o && out_ready_i) begin
      board.check_result(out_speed_o, out_accel_o, status_o, out_last_o);
      quiet_cycles <= 0;
    end
    if (in_valid_i && in_ready_o) begin
      board.note_point(point_time_i, point_speed_i, point_accel_i, limit_valid_i,
                       speed_limit_i, ego_speed_valid_i, ego_speed_i, ego_accel_valid_i,
                       ego_accel_i, in_last_i);
      quiet_cycles <= 0;
    end
    if (quiet_cycles > STALL_MAX) begin
      $display("timeout: no request or result for %0d cycles", STALL_MAX);
      $display("jerk_limited_velocity_profile_unit: mismatch");
      $finish;
    end
  end

  // result side: random back-pressure and one long hold-off
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && board.checked >= 40) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        held = 1;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic write_cfg(logic idx, bit [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DECEL) board.decel = val;
    else board.jerk = val;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    // let the monitor log the last accepted point first
    @(posedge clk_i);
    while (board.result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic drive_point(bit [31:0] t, logic signed [31:0] v, logic signed [31:0] a,
                             bit lv, bit [30:0] lim, bit evv, bit [30:0] ev, bit eav,
                             logic signed [31:0] ea, bit last);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_time_i <= t;
    point_speed_i <= v;
    point_accel_i <= a;
    limit_valid_i <= lv;
    speed_limit_i <= lim;
    ego_speed_valid_i <= evv;
    ego_speed_i <= ev;
    ego_accel_valid_i <= eav;
    ego_accel_i <= ea;
    in_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_traj(int npts, traj_kind_e kind);
    bit [31:0] t;
    bit [30:0] ev, lim;
    logic signed [31:0] v, a, ea;
    bit lv, evv, eav;
    int bad_at;
    ev = $urandom_range(0, 40 << 16);
    evv = ($urandom_range(9) != 0);
    eav = $urandom_range(1);
    ea = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
    t = (kind == TRAJ_ZERO_START) ? 0 : $urandom_range(1, 200000);
    bad_at = $urandom_range(1, (npts > 1) ? npts - 1 : 1);
    for (int i = 0; i < npts; i++) begin
      if (kind == TRAJ_BAD_TIME && i == bad_at)
        t = t - $urandom_range(0, 50000);
      v = $urandom_range(0, 45 << 16);
      if ($urandom_range(15) == 0) v = -v;
      a = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      lv = $urandom_range(1);
      // limits mostly below the ego speed so smoothing kicks in
      lim = (ev > 0) ? $urandom_range(0, ev) : $urandom_range(0, 10 << 16);
      if (kind == TRAJ_WILD) begin
        v = $urandom;
        a = $urandom;
        lim = 31'($urandom);
        if (i == 0) begin
          ev = 31'($urandom);
          ea = $urandom;
        end
      end
      drive_point(t, v, a, lv, lim, evv, ev, eav, ea, i == npts - 1);
      if (kind == TRAJ_WILD && $urandom_range(3) == 0) t = t + $urandom;
      else t = t + $urandom_range(1, 300000);
    end
  endtask

  task automatic random_phase(int quota);
    int stop, r, n;
    traj_kind_e kind;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      n = ($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
      if (r < 70) kind = TRAJ_CLEAN;
      else if (r < 80) kind = TRAJ_ZERO_START;
      else if (r < 90) kind = TRAJ_BAD_TIME;
      else kind = TRAJ_WILD;
      if (kind == TRAJ_BAD_TIME && n < 2) n = 2;
      send_traj(n, kind);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DECEL;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    point_time_i = '0;
    point_speed_i = '0;
    point_accel_i = '0;
    limit_valid_i = 1'b0;
    speed_limit_i = '0;
    ego_speed_valid_i = 1'b0;
    ego_speed_i = '0;
    ego_accel_valid_i = 1'b0;
    ego_accel_i = '0;
    in_last_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short directed trajectories at reset limits
    drive_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    drive_point(32'hffff_ffff, S32_MAX, S32_MIN, 1, 31'h7fff_ffff, 1, 31'h7fff_ffff,
                1, S32_MAX, 1);
    drive_point(100, 5 << 16, 0, 0, 0, 1, 3 << 16, 1, 0, 0);
    drive_point(100, 5 << 16, 0, 0, 0, 0, 0, 0, 0, 1);
    // capped well below ego speed: smoothing
    drive_point(100000, 20 << 16, 0, 0, 0, 1, 20 << 16, 1, 1 << 16, 0);
    drive_point(200000, 20 << 16, 1 << 16, 1, 5 << 16, 0, 0, 0, 0, 0);
    drive_point(900000, 20 << 16, 0, 1, 5 << 16, 0, 0, 0, 0, 1);
    // capped close to ego speed: passed through
    drive_point(100000, 10 << 16, 0, 1, 31'd622592, 1, 10 << 16, 0, 0, 0);
    drive_point(300000, 10 << 16, 0, 0, 0, 0, 0, 0, 0, 1);
    // no ego state, zero first time step
    drive_point(0, 8 << 16, -(1 << 16), 0, 0, 0, 0, 0, 0, 0);
    drive_point(50000, 12 << 16, 2 << 16, 1, 2 << 16, 0, 0, 0, 0, 0);
    drive_point(60000, 12 << 16, 0, 0, 0, 0, 0, 0, 0, 1);
    // extreme values with a cap at zero
    drive_point(1, S32_MIN, S32_MAX, 1, 0, 1, 0, 1, S32_MIN, 0);
    drive_point(2, S32_MAX, S32_MAX, 1, 0, 0, 0, 0, 0, 0);
    drive_point(32'hffff_fffe, S32_MAX, S32_MIN, 1, 31'h7fff_ffff, 0, 0, 0, 0, 1);
    wait_drained();

    random_phase(50);

    write_cfg(CFG_DECEL, 0);
    write_cfg(CFG_JERK, 31'h7fff_ffff);
    random_phase(50);

    no_idle = 1;
    write_cfg(CFG_DECEL, 31'h7fff_ffff);
    write_cfg(CFG_JERK, 31'h7fff_ffff);
    random_phase(50);
    no_idle = 0;

    write_cfg(CFG_DECEL, 0);
    write_cfg(CFG_JERK, 0);
    random_phase(40);

    // overflow: points past the store depth are dropped
    write_cfg(CFG_DECEL, 3 << 16);
    write_cfg(CFG_JERK, 2 << 16);
    send_traj(NPTS + 3, TRAJ_CLEAN);
    wait_drained();

    write_cfg(CFG_DECEL, 31'($urandom));
    write_cfg(CFG_JERK, 31'($urandom));
    random_phase(40);

    write_cfg(CFG_DECEL, 2 << 16);
    write_cfg(CFG_JERK, 4 << 16);
    random_phase(ITEMS_GOAL - items_sent);

    repeat (100) @(posedge clk_i);
    if (board.result_q.size() != 0)
      board.report($sformatf("%0d results never arrived", board.result_q.size()));
    $display("covered %0d points in %0d trajectories, %0d results checked, %0d smoothed",
             items_sent, board.trajs, board.checked, board.smoothed);
    $display("limits swept through zero, maximum, random and typical values");
    if (board.errors == 0) begin
      $display("jerk_limited_velocity_profile_unit: match");
    end else begin
      $display("jerk_limited_velocity_profile_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/jlvp_pkg.sv
rtl/core/jlvp_fifo.sv
rtl/core/jlvp_front.sv
rtl/core/jlvp_muldiv.sv
rtl/core/jlvp_back.sv
rtl/core/jerk_limited_velocity_profile_unit.sv
sim/tb_jerk_limited_velocity_profile_unit.sv
